FILE: src/wms_pkg.sv
package wms_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned HOVER_W = 16;
  localparam int unsigned HOLD_W  = 17;
  localparam int unsigned PASS_W  = 16;
  localparam int unsigned ENTRY_W = 3 * POS_W + HOVER_W;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
  localparam logic [PASS_W-1:0] PASS_MAX = '1;

  localparam logic [3:0] OP_TICK    = 4'd0;
  localparam logic [3:0] OP_APPEND  = 4'd1;
  localparam logic [3:0] OP_CLEAR   = 4'd2;
  localparam logic [3:0] OP_START   = 4'd3;
  localparam logic [3:0] OP_STOP    = 4'd4;
  localparam logic [3:0] OP_PAUSE   = 4'd5;
  localparam logic [3:0] OP_RESUME  = 4'd6;
  localparam logic [3:0] OP_ADVANCE = 4'd7;
  localparam logic [3:0] OP_GOTO    = 4'd8;
  localparam logic [3:0] OP_RESET   = 4'd9;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_PAUSED    = 3'd3;
  localparam logic [2:0] ST_COMPLETED = 3'd4;

  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_LOOP     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_AUTO      = 2'd3;

  typedef struct packed {
    logic exec;
    logic capture;
    logic square;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic needs_table;
  } sts_t;

endpackage

FILE: src/wms_ctrl.sv
module wms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  wms_pkg::sts_t sts_i,
  output wms_pkg::cmd_t cmd_o
);
  import wms_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SQUARE = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign acc         = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (sts_i.needs_table) begin
            cmd_o.capture = 1'b1;
            state_d       = S_SQUARE;
          end else begin
            cmd_o.exec  = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/wms_dp.sv
module wms_dp #(
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [3:0]         op_i,
  input  logic signed [23:0] wp_x_i,
  input  logic signed [23:0] wp_y_i,
  input  logic signed [23:0] wp_z_i,
  input  logic [15:0]        wp_hover_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic [15:0]        elapsed_i,
  input  logic [5:0]         target_index_i,
  input  wms_pkg::cmd_t      cmd_i,
  output wms_pkg::sts_t      sts_o,
  output logic               accepted_o,
  output logic [2:0]         mission_state_o,
  output logic signed [7:0]  current_index_o,
  output logic [6:0]         waypoint_count_o,
  output logic [15:0]        loops_done_o,
  output logic               hovering_o,
  output logic               reached_event_o,
  output logic               completed_event_o,
  output logic               failed_event_o
);
  import wms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned IW = $clog2(MAX_WAYPOINTS);
  localparam int unsigned SW = CW + 1;

  logic [ENTRY_W-1:0] mem_q [MAX_WAYPOINTS];
  logic [ENTRY_W-1:0] rd_q;
  logic               wr_en;

  logic [1:0]          mode_q;
  logic signed [15:0]  limit_q;
  logic [15:0]         thr_q;
  logic                auto_q;

  logic [CW-1:0]        count_q, count_d;
  logic [2:0]           run_q, run_d;
  logic signed [SW-1:0] cur_q, cur_d;
  logic [PASS_W-1:0]    pass_q, pass_d;
  logic                 fwd_q, fwd_d;
  logic                 hold_q, hold_d;
  logic [HOLD_W-1:0]    htime_q, htime_d;
  logic                 acc_q, acc_d, reach_q, reach_d, comp_q, comp_d, fail_q, fail_d;

  logic signed [POS_W-1:0] px_q, py_q, pz_q;
  logic [15:0]             el_q;
  logic [49:0]             sqx_q, sqy_q, sqz_q;
  logic [31:0]             r2_q;

  logic signed [SW-1:0] n_s, c_inc, c_dec, c_two;
  logic signed [SW-1:0] st_cur;
  logic                 st_fwd, st_fin;
  logic [PASS_W-1:0]    p_inc, st_pass;
  logic                 another;

  logic signed [POS_W-1:0] tx, ty, tz;
  logic [HOVER_W-1:0]      thover;
  logic signed [POS_W:0]   dx, dy, dz;
  logic [POS_W:0]          ax, ay, az;
  logic [51:0]             d2;
  logic [HOLD_W:0]         hsum;
  logic [HOLD_W-1:0]       hsat;
  logic                    do_step;

  assign {tx, ty, tz, thover} = rd_q;

  assign sts_o.needs_table = (op_i == OP_TICK) && auto_q && (run_q == ST_RUNNING) &&
                             !cur_q[SW-1] && (cur_q < n_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ONCE;
      limit_q <= '0;
      thr_q   <= 16'd100;
      auto_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:      mode_q  <= cfg_data_i[1:0];
        CFG_LIMIT:     limit_q <= cfg_data_i;
        CFG_THRESHOLD: thr_q   <= cfg_data_i;
        CFG_AUTO:      auto_q  <= cfg_data_i[0];
        default:       mode_q  <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IW-1:0]] <= {wp_x_i, wp_y_i, wp_z_i, wp_hover_i};
    end
    rd_q <= mem_q[cur_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      el_q <= elapsed_i;
    end
    if (cmd_i.square) begin
      sqx_q <= 50'(ax) * 50'(ax);
      sqy_q <= 50'(ay) * 50'(ay);
      sqz_q <= 50'(az) * 50'(az);
      r2_q  <= 32'(thr_q) * 32'(thr_q);
    end
  end

  assign dx = {px_q[POS_W-1], px_q} - {tx[POS_W-1], tx};
  assign dy = {py_q[POS_W-1], py_q} - {ty[POS_W-1], ty};
  assign dz = {pz_q[POS_W-1], pz_q} - {tz[POS_W-1], tz};
  assign ax = dx[POS_W] ? -dx : dx;
  assign ay = dy[POS_W] ? -dy : dy;
  assign az = dz[POS_W] ? -dz : dz;
  assign d2 = 52'(sqx_q) + 52'(sqy_q) + 52'(sqz_q);
  assign hsum = {1'b0, htime_q} + (HOLD_W + 1)'(el_q);
  assign hsat = hsum[HOLD_W] ? HOLD_MAX : hsum[HOLD_W-1:0];

  assign n_s   = $signed({1'b0, count_q});
  assign c_inc = cur_q + SW'(1);
  assign c_dec = cur_q - SW'(1);
  assign c_two = n_s - SW'(2);
  assign p_inc = (pass_q != PASS_MAX) ? pass_q + PASS_W'(1) : pass_q;
  assign another = limit_q[15] || ($signed({1'b0, p_inc}) < $signed({limit_q[15], limit_q}));

  always_comb begin
    st_cur  = cur_q;
    st_fwd  = fwd_q;
    st_pass = pass_q;
    st_fin  = 1'b0;
    case (mode_q)
      MODE_ONCE: begin
        st_cur = c_inc;
        st_fin = (c_inc >= n_s);
      end
      MODE_LOOP: begin
        st_cur = c_inc;
        if (c_inc >= n_s) begin
          st_pass = p_inc;
          if (another) st_cur = '0;
          else st_fin = 1'b1;
        end
      end
      MODE_PINGPONG: begin
        if (fwd_q) begin
          st_cur = c_inc;
          if (c_inc >= n_s) begin
            st_fwd = 1'b0;
            st_cur = c_two;
            if (c_two[SW-1]) begin
              st_pass = p_inc;
              if (another) begin
                st_cur = '0;
                st_fwd = 1'b1;
              end else begin
                st_fin = 1'b1;
              end
            end
          end
        end else begin
          st_cur = c_dec;
          if (c_dec[SW-1]) begin
            st_pass = p_inc;
            if (another) begin
              st_cur = (count_q == CW'(1)) ? SW'(0) : SW'(1);
              st_fwd = 1'b1;
            end else begin
              st_fin = 1'b1;
            end
          end
        end
      end
      default: begin
        st_cur = cur_q;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    run_d   = run_q;
    cur_d   = cur_q;
    pass_d  = pass_q;
    fwd_d   = fwd_q;
    hold_d  = hold_q;
    htime_d = htime_q;
    acc_d   = acc_q;
    reach_d = reach_q;
    comp_d  = comp_q;
    fail_d  = fail_q;
    wr_en   = 1'b0;
    do_step = 1'b0;
    if (cmd_i.exec) begin
      acc_d   = 1'b0;
      reach_d = 1'b0;
      comp_d  = 1'b0;
      fail_d  = 1'b0;
      case (op_i)
        OP_TICK: acc_d = 1'b1;
        OP_APPEND: begin
          if (count_q < CW'(MAX_WAYPOINTS)) begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
            if (run_q == ST_IDLE) run_d = ST_READY;
            acc_d = 1'b1;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
          cur_d   = '0;
          pass_d  = '0;
          fwd_d   = 1'b1;
          run_d   = ST_IDLE;
          acc_d   = 1'b1;
        end
        OP_START: begin
          if (count_q == '0) begin
            fail_d = 1'b1;
          end else if (run_q != ST_RUNNING) begin
            cur_d   = '0;
            pass_d  = '0;
            fwd_d   = 1'b1;
            hold_d  = 1'b0;
            htime_d = '0;
            run_d   = ST_RUNNING;
            acc_d   = 1'b1;
          end
        end
        OP_STOP: begin
          if (run_q != ST_IDLE) begin
            cur_d   = '0;
            pass_d  = '0;
            fwd_d   = 1'b1;
            hold_d  = 1'b0;
            htime_d = '0;
            run_d   = ST_IDLE;
            acc_d   = 1'b1;
          end
        end
        OP_PAUSE: begin
          if (run_q == ST_RUNNING) begin
            run_d = ST_PAUSED;
            acc_d = 1'b1;
          end
        end
        OP_RESUME: begin
          if (run_q == ST_PAUSED) begin
            run_d = ST_RUNNING;
            acc_d = 1'b1;
          end
        end
        OP_ADVANCE: begin
          if (run_q == ST_RUNNING || run_q == ST_PAUSED) begin
            do_step = 1'b1;
            acc_d   = 1'b1;
          end
        end
        OP_GOTO: begin
          if (32'(target_index_i) < 32'(count_q)) begin
            cur_d   = SW'($signed({1'b0, target_index_i}));
            hold_d  = 1'b0;
            htime_d = '0;
            acc_d   = 1'b1;
          end
        end
        OP_RESET: begin
          cur_d   = '0;
          pass_d  = '0;
          fwd_d   = 1'b1;
          hold_d  = 1'b0;
          htime_d = '0;
          run_d   = (count_q != '0) ? ST_READY : ST_IDLE;
          acc_d   = 1'b1;
        end
        default: acc_d = 1'b0;
      endcase
    end
    if (cmd_i.finish) begin
      acc_d   = 1'b1;
      reach_d = 1'b0;
      comp_d  = 1'b0;
      fail_d  = 1'b0;
      if (hold_q) begin
        htime_d = hsat;
        if (hsat >= HOLD_W'(thover)) begin
          hold_d  = 1'b0;
          htime_d = '0;
          do_step = 1'b1;
        end
      end else if (d2 <= 52'(r2_q)) begin
        if (thover != '0) begin
          hold_d  = 1'b1;
          htime_d = '0;
        end else begin
          do_step = 1'b1;
        end
      end
    end
    if (do_step) begin
      cur_d   = st_cur;
      fwd_d   = st_fwd;
      pass_d  = st_pass;
      reach_d = 1'b1;
      if (st_fin) begin
        run_d  = ST_COMPLETED;
        comp_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      run_q   <= ST_IDLE;
      cur_q   <= '0;
      pass_q  <= '0;
      fwd_q   <= 1'b1;
      hold_q  <= 1'b0;
      htime_q <= '0;
      acc_q   <= 1'b0;
      reach_q <= 1'b0;
      comp_q  <= 1'b0;
      fail_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      run_q   <= run_d;
      cur_q   <= cur_d;
      pass_q  <= pass_d;
      fwd_q   <= fwd_d;
      hold_q  <= hold_d;
      htime_q <= htime_d;
      acc_q   <= acc_d;
      reach_q <= reach_d;
      comp_q  <= comp_d;
      fail_q  <= fail_d;
    end
  end

  assign accepted_o        = acc_q;
  assign mission_state_o   = run_q;
  assign current_index_o   = 8'(cur_q);
  assign waypoint_count_o  = 7'(count_q);
  assign loops_done_o      = pass_q;
  assign hovering_o        = hold_q;
  assign reached_event_o   = reach_q;
  assign completed_event_o = comp_q;
  assign failed_event_o    = fail_q;

endmodule

FILE: src/waypoint_mission_sequencer_unit.sv
// Latency: commands and ticks that skip the arrival check give their result in the
// cycle after they are taken; ticks that check arrival go through table read, squaring, compare.
// Flow: one transfer at a time; the next is taken once the result leaves.
// Reset: rst_ni clears mission state and configuration registers; the waypoint table is
// not cleared and holds data only below the waypoint count.
module waypoint_mission_sequencer_unit #(
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         op_i,
  input  logic signed [23:0] wp_x_i,
  input  logic signed [23:0] wp_y_i,
  input  logic signed [23:0] wp_z_i,
  input  logic [15:0]        wp_hover_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic [15:0]        elapsed_i,
  input  logic [5:0]         target_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [2:0]         mission_state_o,
  output logic signed [7:0]  current_index_o,
  output logic [6:0]         waypoint_count_o,
  output logic [15:0]        loops_done_o,
  output logic               hovering_o,
  output logic               reached_event_o,
  output logic               completed_event_o,
  output logic               failed_event_o
);
  import wms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wms_dp #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .wp_x_i            (wp_x_i),
    .wp_y_i            (wp_y_i),
    .wp_z_i            (wp_z_i),
    .wp_hover_i        (wp_hover_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pos_z_i           (pos_z_i),
    .elapsed_i         (elapsed_i),
    .target_index_i    (target_index_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .accepted_o        (accepted_o),
    .mission_state_o   (mission_state_o),
    .current_index_o   (current_index_o),
    .waypoint_count_o  (waypoint_count_o),
    .loops_done_o      (loops_done_o),
    .hovering_o        (hovering_o),
    .reached_event_o   (reached_event_o),
    .completed_event_o (completed_event_o),
    .failed_event_o    (failed_event_o)
  );

`ifndef SYNTH
  a_stall_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated after transfer");

  a_complete_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && completed_event_o |-> mission_state_o == ST_COMPLETED)
    else $error("completion reported outside completed state");
`endif

endmodule
